// ===== hdl/owd_pkg.sv =====
// Shared types and constants for the cell open-wire detector.
`default_nettype none

package owd_pkg;

  // Per-cell entry kept in the cell memory
  typedef struct packed {
    logic               end_low;  // end-pin reading at or below the floor
    logic               err;      // one of the readings is invalid
    logic [3:0]         code;     // fault code of the first invalid reading
    logic               usable;   // both readings valid
    logic signed [16:0] delta;    // pull-up minus pull-down
  } entry_t;

  // Control from the sequencer to the pin walker
  typedef struct packed {
    logic clear;  // start of a walk: drop old pin flags
    logic step;   // a cell entry is presented this cycle
    logic first;  // entry belongs to cell 0
    logic last;   // entry belongs to the last cell
  } walk_ctl_t;

  // Result verdicts
  localparam logic [1:0] VERDICT_OK    = 2'd0;
  localparam logic [1:0] VERDICT_OPEN  = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic REG_DELTA_THR = 1'b0;
  localparam logic REG_FLOOR     = 1'b1;

  localparam int unsigned THR_W = 16;

endpackage

`default_nettype wire

// ===== hdl/owd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module owd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/owd_cell_calc.sv =====
// Builds the stored entry of one cell from its even and odd readings.
`default_nettype none

module owd_cell_calc #(
  parameter int unsigned CELLS = 16
) (
  input  wire logic                       even_ok,
  input  wire logic [15:0]                even_volts,
  input  wire logic [3:0]                 even_fault,
  input  wire logic                       odd_ok,
  input  wire logic [15:0]                odd_volts,
  input  wire logic [3:0]                 odd_fault,
  input  wire logic [$clog2(CELLS)-1:0]   cell_idx,
  input  wire logic [owd_pkg::THR_W-1:0]  floor_voltage,
  output owd_pkg::entry_t                 entry
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

  logic signed [16:0] even_minus_odd;
  logic               first_low;
  logic               last_low;

  assign even_minus_odd = $signed({1'b0, even_volts}) - $signed({1'b0, odd_volts});

  // end-pin checks against the floor
  assign first_low = (cell_idx == '0) && even_ok && (even_volts <= floor_voltage);
  assign last_low  = (cell_idx == LAST_IDX) && odd_ok && (odd_volts <= floor_voltage);

  always_comb begin
    entry         = '0;
    entry.end_low = first_low | last_low;
    entry.usable  = even_ok & odd_ok;
    // even reading's error wins
    if (!even_ok) begin
      entry.err  = 1'b1;
      entry.code = even_fault;
    end else if (!odd_ok) begin
      entry.err  = 1'b1;
      entry.code = odd_fault;
    end
    // even cells: even minus odd; odd cells: odd minus even
    if (even_ok && odd_ok) begin
      entry.delta = cell_idx[0] ? -even_minus_odd : even_minus_odd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/owd_pin_walk.sv =====
// Walks adjacent cell pairs in order and keeps the open flag of every pin.
`default_nettype none

module owd_pin_walk #(
  parameter int unsigned CELLS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire owd_pkg::walk_ctl_t        ctl,
  input  wire logic [$clog2(CELLS)-1:0]  pin_idx,   // lower pin of the pair
  input  wire owd_pkg::entry_t           cur,       // upper cell of the pair
  input  wire logic [owd_pkg::THR_W-1:0] thr,
  output logic      [CELLS:0]            pins
);

  owd_pkg::entry_t   prev_r, prev_nxt;
  logic              in_run_r, in_run_nxt;
  logic [CELLS:0]    pins_r, pins_nxt;

  logic signed [17:0] thr_s;
  logic signed [17:0] d_prev;
  logic signed [17:0] d_diff;
  logic               pair_ok;
  logic               start;
  logic               cont;
  logic [CELLS:0]     set_mask;

  assign thr_s   = $signed({2'b00, thr});
  assign d_prev  = $signed({prev_r.delta[16], prev_r.delta});
  assign d_diff  = $signed({cur.delta[16], cur.delta}) - d_prev;
  assign pair_ok = prev_r.usable & cur.usable;

  // a run starts on a large delta or carries on from the last pair
  assign start    = in_run_r | (pair_ok & (d_prev > thr_s));
  assign cont     = start & pair_ok & (d_diff >= thr_s);
  assign set_mask = {{(CELLS - 1){1'b0}}, cont, start} << pin_idx;

  always_comb begin
    prev_nxt   = prev_r;
    in_run_nxt = in_run_r;
    pins_nxt   = pins_r;
    if (ctl.clear) begin
      pins_nxt   = '0;
      in_run_nxt = 1'b0;
    end else if (ctl.step) begin
      prev_nxt = cur;
      if (ctl.first) begin
        pins_nxt[0] = pins_r[0] | cur.end_low;
      end else begin
        pins_nxt   = pins_r | set_mask;
        in_run_nxt = cont;
        if (ctl.last) begin
          pins_nxt[CELLS] = pins_r[CELLS] | cur.end_low;
          in_run_nxt      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
      pins_r   <= '0;
    end else begin
      in_run_r <= in_run_nxt;
      pins_r   <= pins_nxt;
    end
  end

  // previous cell entry, payload only
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

  assign pins = pins_r;

endmodule

`default_nettype wire

// ===== hdl/cell_open_wire_detector.sv =====
// Top level of the open-wire detector: load, pin walk and result emission.
//
//  channel  | direction | content
//  ---------+-----------+------------------------------------------------
//  in_      | slave     | one cell's even and odd readings per transfer
//  out_     | master    | one verdict per cell, tlast on the final cell
//  cfg_     | write     | delta threshold (0), floor voltage (1)
//
// A segment is loaded at one cell per cycle (CELLS transfers). After the last
// cell the walk reads the cell memory once per cell, then emission reads it
// again once per result, stalling on a full output register; the single memory
// read port serves both passes. Input is held off during walk and emission.
// Reset is synchronous; the memory needs no clearing pass. The output
// register lets loading of the next segment start while the last result waits.
`default_nettype none

module cell_open_wire_detector #(
  parameter int unsigned CELLS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // even_ok[0], even_volts[16:1], even_fault[20:17],
  // odd_ok[21], odd_volts[37:22], odd_fault[41:38], zero fill [47:42]
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cell_number[3:0], verdict[5:4], fault_code[9:6], zero fill [15:10]
  output logic      [15:0] out_tdata,
  output logic             out_tlast,   // last_of_segment
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned CW = $clog2(CELLS + 1);
  localparam int unsigned EW = $bits(owd_pkg::entry_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
  localparam logic [CW-1:0] WALK_END = CW'(CELLS);

  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_WALK    = 2'd1;
  localparam logic [1:0] ST_EMIT_RD = 2'd2;
  localparam logic [1:0] ST_EMIT_OUT = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CW-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [AW-1:0] emit_cnt_r, emit_cnt_nxt;

  logic [15:0]   thr_r, thr_nxt;
  logic [15:0]   floor_r, floor_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_fire;
  logic          out_free;

  owd_pkg::entry_t   new_entry;
  owd_pkg::entry_t   rd_entry;
  logic [EW-1:0]     ram_rdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;

  owd_pkg::walk_ctl_t walk_ctl;
  logic [AW-1:0]      pin_idx;
  logic [CELLS:0]     pins;
  logic [CELLS:0]     pins_sh;

  logic [1:0] verdict;
  logic [3:0] fault_code;

  assign in_tready = (state_r == ST_LOAD);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // entry of the cell being loaded
  owd_cell_calc #(
    .CELLS(CELLS)
  ) u_cell_calc (
    .even_ok       (in_tdata[0]),
    .even_volts    (in_tdata[16:1]),
    .even_fault    (in_tdata[20:17]),
    .odd_ok        (in_tdata[21]),
    .odd_volts     (in_tdata[37:22]),
    .odd_fault     (in_tdata[41:38]),
    .cell_idx      (load_cnt_r),
    .floor_voltage (floor_r),
    .entry         (new_entry)
  );

  // cell memory
  owd_ram #(
    .WIDTH(EW),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt_r),
    .wdata (new_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = owd_pkg::entry_t'(ram_rdata);

  // memory read address: walk pointer or emission pointer
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = emit_cnt_r;
    case (state_r)
      ST_WALK: begin
        ram_re    = (walk_cnt_r != WALK_END);
        ram_raddr = walk_cnt_r[AW-1:0];
      end
      ST_EMIT_RD: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // walker control: data read last cycle belongs to cell walk_cnt_r - 1
  always_comb begin
    walk_ctl.clear = in_fire && (load_cnt_r == LAST_IDX);
    walk_ctl.step  = (state_r == ST_WALK) && (walk_cnt_r != '0);
    walk_ctl.first = (walk_cnt_r == CW'(1));
    walk_ctl.last  = (walk_cnt_r == WALK_END);
  end
  assign pin_idx = AW'(walk_cnt_r - CW'(2));

  owd_pin_walk #(
    .CELLS(CELLS)
  ) u_pin_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (walk_ctl),
    .pin_idx (pin_idx),
    .cur     (rd_entry),
    .thr     (thr_r),
    .pins    (pins)
  );

  // verdict of the cell read for emission
  assign pins_sh = pins >> emit_cnt_r;
  always_comb begin
    fault_code = '0;
    if (rd_entry.err) begin
      verdict    = owd_pkg::VERDICT_ERROR;
      fault_code = rd_entry.code;
    end else if (pins_sh[0] | pins_sh[1]) begin
      verdict = owd_pkg::VERDICT_OPEN;
    end else begin
      verdict = owd_pkg::VERDICT_OK;
    end
  end

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    walk_cnt_nxt  = walk_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_cnt_r == LAST_IDX) begin
            load_cnt_nxt = '0;
            walk_cnt_nxt = '0;
            state_nxt    = ST_WALK;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (walk_cnt_r == WALK_END) begin
          emit_cnt_nxt = '0;
          state_nxt    = ST_EMIT_RD;
        end else begin
          walk_cnt_nxt = walk_cnt_r + 1'b1;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, fault_code, verdict, 4'(emit_cnt_r)};
          out_last_nxt  = (emit_cnt_r == LAST_IDX);
          if (emit_cnt_r == LAST_IDX) begin
            state_nxt = ST_LOAD;
          end else begin
            emit_cnt_nxt = emit_cnt_r + 1'b1;
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // configuration writes
  always_comb begin
    thr_nxt   = thr_r;
    floor_nxt = floor_r;
    if (cfg_we) begin
      case (cfg_addr)
        owd_pkg::REG_DELTA_THR: thr_nxt   = cfg_wdata;
        owd_pkg::REG_FLOOR:     floor_nxt = cfg_wdata;
        default:                thr_nxt   = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      walk_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= 16'd4000;
      floor_r     <= 16'd15000;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      floor_r     <= floor_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // the last cell of a segment closes the input until emission is done
  a_load_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (load_cnt_r == LAST_IDX)) |=> !in_tready)
    else $error("input still open after last cell of segment");

  // tlast only on the final cell's result
  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[3:0] == 4'(CELLS - 1)))
    else $error("tlast on a cell other than the last");

  // fault code is only carried with an error verdict
  a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[5:4] != owd_pkg::VERDICT_ERROR)) |-> (out_tdata[9:6] == 4'd0))
    else $error("fault code without error verdict");

  // walk pointer stays within one pass over the cells
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (walk_cnt_r <= WALK_END))
    else $error("walk pointer out of range");

  // a result is only loaded when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== verif/cell_open_wire_detector_tb.sv =====
// Self-checking testbench for the cell open-wire detector, top module testbench.
`default_nettype none

module testbench;

  localparam int unsigned CELLS       = 16;
  localparam int unsigned IDLE_CYCLES = 3 * CELLS + 20;
  localparam int unsigned MAX_CYCLES  = 400000;

  // One cell's readings as they travel in in_tdata (last field lowest)
  typedef struct packed {
    logic [5:0]  pad;
    logic [3:0]  odd_fault;
    logic [15:0] odd_volts;
    logic        odd_ok;
    logic [3:0]  even_fault;
    logic [15:0] even_volts;
    logic        even_ok;
  } reading_t;

  // One predicted result transfer
  typedef struct {
    logic [3:0] cell_num;
    logic [1:0] verdict;
    logic [3:0] code;
    logic       last;
  } cell_verdict_t;

  // Shapes of generated segments
  typedef enum {SEG_CLEAN, SEG_FAULTY, SEG_NOISE} seg_kind_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  // even_ok[0], even_volts[16:1], even_fault[20:17],
  // odd_ok[21], odd_volts[37:22], odd_fault[41:38], zero fill [47:42]
  logic [47:0] in_tdata  = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // cell_number[3:0], verdict[5:4], fault_code[9:6], zero fill [15:10]
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = owd_pkg::REG_DELTA_THR;
  logic [15:0] cfg_wdata  = '0;

  // Predictor state: register copies, cell memory, load position
  logic [15:0]     cur_thr   = 16'd4000;
  logic [15:0]     cur_floor = 16'd15000;
  owd_pkg::entry_t cell_mem [CELLS];
  int unsigned     load_idx  = 0;
  cell_verdict_t   verdict_queue [$];

  int unsigned errors  = 0;
  int unsigned cycles  = 0;
  bit          no_idle = 1'b0;

  cell_open_wire_detector #(.CELLS(CELLS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Pin walk over the loaded segment, then one verdict per cell
  function automatic void predict_verdicts();
    bit            pin_open [CELLS+1];
    int            n;
    int            thr;
    bit            active;
    cell_verdict_t v;
    thr = int'(cur_thr);
    foreach (pin_open[i]) pin_open[i] = 1'b0;
    n = 0;
    while (n + 1 < CELLS) begin
      if (cell_mem[n].usable && cell_mem[n+1].usable &&
          int'($signed(cell_mem[n].delta)) > thr) begin
        pin_open[n] = 1'b1;
        active = 1'b1;
        // a run continues while each next delta climbs by the threshold
        while (active && n + 1 < CELLS && cell_mem[n].usable && cell_mem[n+1].usable) begin
          if (int'($signed(cell_mem[n+1].delta)) - int'($signed(cell_mem[n].delta)) >= thr)
          begin
            pin_open[n+1] = 1'b1;
            n++;
          end else begin
            active = 1'b0;
          end
        end
      end
      n++;
    end
    if (cell_mem[0].end_low) pin_open[0] = 1'b1;
    if (cell_mem[CELLS-1].end_low) pin_open[CELLS] = 1'b1;
    for (int k = 0; k < CELLS; k++) begin
      v.cell_num = 4'(k);
      v.code     = '0;
      v.last     = (k == CELLS - 1);
      if (cell_mem[k].err) begin
        v.verdict = owd_pkg::VERDICT_ERROR;
        v.code    = cell_mem[k].code;
      end else if (pin_open[k] || pin_open[k+1]) begin
        v.verdict = owd_pkg::VERDICT_OPEN;
      end else begin
        v.verdict = owd_pkg::VERDICT_OK;
      end
      verdict_queue.push_back(v);
    end
  endfunction

  // Store one accepted cell; the segment's last cell triggers prediction
  function automatic void load_cell(input reading_t r);
    owd_pkg::entry_t e;
    int              diff;
    e = '0;
    if (!r.even_ok) begin
      e.err  = 1'b1;
      e.code = r.even_fault;
    end else if (!r.odd_ok) begin
      e.err  = 1'b1;
      e.code = r.odd_fault;
    end
    if (load_idx == 0 && r.even_ok && r.even_volts <= cur_floor) e.end_low = 1'b1;
    if (load_idx == CELLS - 1 && r.odd_ok && r.odd_volts <= cur_floor) e.end_low = 1'b1;
    e.usable = r.even_ok && r.odd_ok;
    if (e.usable) begin
      // pull-up minus pull-down flips with cell parity
      if (load_idx % 2 == 1) diff = int'(r.odd_volts) - int'(r.even_volts);
      else diff = int'(r.even_volts) - int'(r.odd_volts);
      e.delta = 17'(diff);
    end
    cell_mem[load_idx] = e;
    if (load_idx == CELLS - 1) begin
      load_idx = 0;
      predict_verdicts();
    end else begin
      load_idx++;
    end
  endfunction

  // Cell readings with both switches valid and a chosen delta
  function automatic reading_t valid_cell(input int c, input int d);
    reading_t r;
    int       lo, hi, dn, up;
    r = '0;
    r.even_ok    = 1'b1;
    r.odd_ok     = 1'b1;
    r.even_fault = 4'($urandom_range(15, 0));
    r.odd_fault  = 4'($urandom_range(15, 0));
    if (d > 65535) d = 65535;
    if (d < -65535) d = -65535;
    lo = (d < 0) ? -d : 0;
    hi = (d > 0) ? 65535 - d : 65535;
    dn = int'($urandom_range(hi, lo));
    up = dn + d;
    if (c % 2 == 0) begin
      r.even_volts = 16'(up);
      r.odd_volts  = 16'(dn);
    end else begin
      r.odd_volts  = 16'(up);
      r.even_volts = 16'(dn);
    end
    return r;
  endfunction

  function automatic reading_t cell_reading(input logic eok, input int ev, input int ef,
                                            input logic ook, input int ov, input int of);
    reading_t r;
    r = '0;
    r.even_ok    = eok;
    r.even_volts = 16'(ev);
    r.even_fault = 4'(ef);
    r.odd_ok     = ook;
    r.odd_volts  = 16'(ov);
    r.odd_fault  = 4'(of);
    return r;
  endfunction

  // Sender: random gap, then hold the transfer until accepted
  task automatic send_cell(input reading_t r);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(13, 0));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    load_cell(r);
  endtask

  // Drop valid, drain all results, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called while the block is idle
  task automatic set_regs(input logic [15:0] thr, input logic [15:0] floor_v);
    cfg_we    <= 1'b1;
    cfg_addr  <= owd_pkg::REG_DELTA_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_addr  <= owd_pkg::REG_FLOOR;
    cfg_wdata <= floor_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thr   = thr;
    cur_floor = floor_v;
    @(posedge clk);
  endtask

  // One whole segment of generated cells
  task automatic run_segment(input seg_kind_t kind);
    int       d [CELLS];
    int       thr, s, len, v;
    reading_t r;
    thr = int'(cur_thr);
    // background deltas lie between minus and plus the threshold, boundary included
    foreach (d[c]) d[c] = int'($urandom_range(2 * thr, 0)) - thr;
    // inject rising runs that should open a chain of pins
    repeat ($urandom_range(2, 0)) begin
      s   = int'($urandom_range(CELLS - 2, 0));
      len = int'($urandom_range(5, 1));
      d[s] = thr + 1 + int'($urandom_range(thr / 4, 0));
      for (int k = 1; k <= len && s + k < CELLS; k++)
        d[s+k] = d[s+k-1] + thr + int'($urandom_range(2, 0)) - 1;
    end
    for (int c = 0; c < CELLS; c++) begin
      if (kind == SEG_NOISE) begin
        r = reading_t'(48'({$urandom(), $urandom()}));
        r.pad = '0;
      end else begin
        r = valid_cell(c, d[c]);
        if (kind == SEG_FAULTY && $urandom_range(4, 0) == 0) begin
          case ($urandom_range(2, 0))
            0: r.even_ok = 1'b0;
            1: r.odd_ok  = 1'b0;
            default: begin
              r.even_ok = 1'b0;
              r.odd_ok  = 1'b0;
            end
          endcase
        end
        // end-pin readings around the floor
        v = int'(cur_floor) + int'($urandom_range(2, 0)) - 1;
        v = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
        if (c == 0 && $urandom_range(2, 0) == 0) r.even_volts = 16'(v);
        if (c == CELLS - 1 && $urandom_range(2, 0) == 0) r.odd_volts = 16'(v);
      end
      send_cell(r);
    end
  endtask

  // Receiver: random stall before each result
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : int'($urandom_range(13, 0));
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checker: each transfer against the oldest prediction
  initial begin
    cell_verdict_t exp_v;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (verdict_queue.size() == 0) begin
          $error("unexpected result transfer: tdata %h tlast %b", out_tdata, out_tlast);
          errors++;
        end else begin
          exp_v = verdict_queue.pop_front();
          if (out_tdata[3:0] !== exp_v.cell_num) begin
            $error("cell_number: expected %0d, got %0d", exp_v.cell_num, out_tdata[3:0]);
            errors++;
          end
          if (out_tdata[5:4] !== exp_v.verdict) begin
            $error("verdict: expected %0d, got %0d", exp_v.verdict, out_tdata[5:4]);
            errors++;
          end
          if (out_tdata[9:6] !== exp_v.code) begin
            $error("fault_code: expected %0d, got %0d", exp_v.code, out_tdata[9:6]);
            errors++;
          end
          if (out_tlast !== exp_v.last) begin
            $error("last_of_segment: expected %0d, got %0d", exp_v.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Hand-built segment under reset register values
  task automatic test_directed_segment();
    send_cell(cell_reading(1, 15000, 0, 1, 12000, 0));   // pin 0 at the floor
    send_cell(cell_reading(1, 20000, 0, 1, 25000, 0));   // delta above threshold
    send_cell(cell_reading(1, 29000, 0, 1, 20000, 0));   // rise of exactly threshold
    send_cell(cell_reading(1, 20000, 0, 1, 32999, 0));   // rise one short, run ends
    send_cell(cell_reading(0, 65535, 15, 0, 0, 9));      // both invalid: even code wins
    send_cell(cell_reading(1, 65535, 3, 0, 65535, 7));   // odd invalid only
    send_cell(cell_reading(1, 65535, 0, 1, 0, 0));       // largest positive delta
    send_cell(cell_reading(1, 65535, 0, 1, 0, 0));       // most negative delta
    send_cell(cell_reading(1, 0, 0, 1, 65535, 0));
    send_cell(cell_reading(1, 0, 0, 1, 65535, 0));
    send_cell(cell_reading(1, 30000, 0, 1, 30000, 0));   // zero delta
    send_cell(cell_reading(1, 30000, 0, 1, 30000, 0));
    send_cell(cell_reading(0, 30000, 0, 1, 30000, 0));   // error with code zero
    send_cell(cell_reading(1, 30000, 0, 1, 30000, 0));
    send_cell(cell_reading(1, 30000, 0, 1, 30000, 0));
    send_cell(cell_reading(1, 40000, 0, 1, 0, 0));       // last pin reading zero
    wait_idle();
  endtask

  // Register corners, each with a clean and a noisy segment
  task automatic test_register_extremes();
    logic [15:0] thr_set   [4] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
    logic [15:0] floor_set [4] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
    for (int i = 0; i < 4; i++) begin
      set_regs(thr_set[i], floor_set[i]);
      run_segment(SEG_CLEAN);
      run_segment(SEG_NOISE);
      wait_idle();
    end
  endtask

  // Random phases; each drains fully before the registers change
  task automatic test_random_segments();
    logic [15:0] thr, floor_v;
    int          m;
    for (int phase = 0; phase < 6; phase++) begin
      thr     = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 0))
                                            : 16'($urandom_range(8000, 0));
      floor_v = 16'($urandom_range(65535, 0));
      set_regs(thr, floor_v);
      no_idle = (phase == 3);
      repeat (3) begin
        m = int'($urandom_range(9, 0));
        run_segment(m < 5 ? SEG_CLEAN : (m < 8 ? SEG_FAULTY : SEG_NOISE));
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_segment();
    test_register_extremes();
    test_random_segments();
    wait_idle();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/owd_pkg.sv
hdl/owd_ram.sv
hdl/owd_cell_calc.sv
hdl/owd_pin_walk.sv
hdl/cell_open_wire_detector.sv
verif/cell_open_wire_detector_tb.sv
